>>> hdl/bpit_pkg.sv
// Shared constants for the barycentric point-in-triangle core.
package bpit_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int THRESH_WIDTH        = 62;
   localparam int NUM_STAGES          = 7;

endpackage

>>> hdl/barycentric_point_in_triangle_core.sv
// Pipelined barycentric point-in-triangle test with degenerate-triangle threshold.
//
// One query (triangle A, B, C and point P, signed Q8.8) enters per clock unless
// rsp_ready holds results back; each query passes the seven-stage pipeline:
// edge vectors, edge products, dot sums, half-word partial products of the
// second-level products, their recombination, determinant and numerators, then
// the exact comparisons. Each stage stalls only when it is full
// and the stage after it cannot take its item, so bubbles collapse and a query
// is taken while a result waits on rsp_ready. The threshold register may be
// written only while the pipeline is empty; csr_ready is always high.
module barycentric_point_in_triangle_core #(
   parameter int COORD_WIDTH = bpit_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpit_pkg::THRESH_WIDTH-1:0]   csr_wdata,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_a_x,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_a_y,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_a_z,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_b_x,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_b_y,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_b_z,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_c_x,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_c_y,
   input  logic signed [COORD_WIDTH-1:0]       req_vertex_c_z,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_inside_res,
   output logic                                rsp_degenerate
);
   import bpit_pkg::*;

   localparam int EW   = COORD_WIDTH + 1;     // edge vector component
   localparam int PW   = 2 * EW;              // edge product
   localparam int DW   = PW + 2;              // dot product
   localparam int HW   = (DW + 1) / 2;        // low half of a dot product
   localparam int GW   = DW - HW;             // high half of a dot product
   localparam int QW   = 2 * DW;              // second-level product
   localparam int RW   = QW + 1;              // det, nu, nv
   localparam int SW   = RW + 1;              // nu + nv
   localparam int CMPW = (RW > THRESH_WIDTH + 1) ? RW : THRESH_WIDTH + 1;
   localparam int NS   = NUM_STAGES;

   // dot products: d00, d01, d02, d11, d12 as (edge, edge)
   localparam int unsigned DOT_A [5] = '{0, 0, 0, 1, 1};
   localparam int unsigned DOT_B [5] = '{0, 1, 2, 1, 2};
   localparam int D00 = 0;
   localparam int D01 = 1;
   localparam int D02 = 2;
   localparam int D11 = 3;
   localparam int D12 = 4;
   // products: d00*d11, d01*d01, d11*d02, d01*d12, d00*d12, d01*d02
   localparam int unsigned PRD_A [6] = '{D00, D01, D11, D01, D00, D01};
   localparam int unsigned PRD_B [6] = '{D11, D01, D02, D12, D12, D02};

   logic [NS-1:0] stage_en;
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;

   logic [THRESH_WIDTH-1:0] threshold_ff;
   logic [THRESH_WIDTH-1:0] threshold_in;

   logic signed [EW-1:0] edge_ff [3][3];
   logic signed [EW-1:0] edge_in [3][3];
   logic signed [PW-1:0] eprod_ff [15];
   logic signed [PW-1:0] eprod_in [15];
   logic signed [DW-1:0] dot_ff [5];
   logic signed [DW-1:0] dot_in [5];
   logic signed [QW-1:0] part_ff [6][4];
   logic signed [QW-1:0] part_in [6][4];
   logic signed [QW-1:0] prd_ff [6];
   logic signed [QW-1:0] prd_in [6];
   logic signed [RW-1:0] det_ff, nu_ff, nv_ff;
   logic signed [RW-1:0] det_in, nu_in, nv_in;
   logic                 inside_ff, degen_ff;
   logic                 inside_in, degen_in;

   // ready chain: a stage takes a new item when empty or when it hands its own on
   always_comb begin
      stage_en[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NS; i++) begin
         if (stage_en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   assign csr_ready    = 1'b1;
   assign threshold_in = (csr_valid && csr_ready) ? csr_wdata : threshold_ff;
   assign req_ready    = stage_en[0];
   assign rsp_valid    = valid_ff[NS-1];
   assign rsp_inside_res = inside_ff;
   assign rsp_degenerate = degen_ff;

   // stage 1: edge vectors e0 = C - A, e1 = B - A, e2 = P - A
   always_comb begin
      edge_in[0][0] = EW'(req_vertex_c_x) - EW'(req_vertex_a_x);
      edge_in[0][1] = EW'(req_vertex_c_y) - EW'(req_vertex_a_y);
      edge_in[0][2] = EW'(req_vertex_c_z) - EW'(req_vertex_a_z);
      edge_in[1][0] = EW'(req_vertex_b_x) - EW'(req_vertex_a_x);
      edge_in[1][1] = EW'(req_vertex_b_y) - EW'(req_vertex_a_y);
      edge_in[1][2] = EW'(req_vertex_b_z) - EW'(req_vertex_a_z);
      edge_in[2][0] = EW'(req_point_x) - EW'(req_vertex_a_x);
      edge_in[2][1] = EW'(req_point_y) - EW'(req_vertex_a_y);
      edge_in[2][2] = EW'(req_point_z) - EW'(req_vertex_a_z);
   end

   // stage 2: component products
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         for (int j = 0; j < 3; j++) begin
            eprod_in[k*3+j] = edge_ff[DOT_A[k]][j] * edge_ff[DOT_B[k]][j];
         end
      end
   end

   // stage 3: dot sums
   always_comb begin
      for (int k = 0; k < 5; k++) begin
         dot_in[k] = DW'(eprod_ff[k*3]) + DW'(eprod_ff[k*3+1]) + DW'(eprod_ff[k*3+2]);
      end
   end

   // stage 4: half-word partial products, low halves unsigned
   always_comb begin
      logic signed [HW:0]       lo_a, lo_b;
      logic signed [GW-1:0]     hi_a, hi_b;
      logic signed [2*HW+1:0]   ll;
      logic signed [DW:0]       lh, hl;
      logic signed [2*GW-1:0]   hh;
      for (int k = 0; k < 6; k++) begin
         lo_a = $signed({1'b0, dot_ff[PRD_A[k]][HW-1:0]});
         lo_b = $signed({1'b0, dot_ff[PRD_B[k]][HW-1:0]});
         hi_a = $signed(dot_ff[PRD_A[k]][DW-1:HW]);
         hi_b = $signed(dot_ff[PRD_B[k]][DW-1:HW]);
         ll = lo_a * lo_b;
         lh = lo_a * hi_b;
         hl = hi_a * lo_b;
         hh = hi_a * hi_b;
         part_in[k][0] = QW'(ll);
         part_in[k][1] = QW'(lh);
         part_in[k][2] = QW'(hl);
         part_in[k][3] = QW'(hh);
      end
   end

   // stage 5: recombine
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         prd_in[k] = (part_ff[k][3] <<< (2 * HW))
                   + ((part_ff[k][1] + part_ff[k][2]) <<< HW)
                   + part_ff[k][0];
      end
   end

   // stage 6: determinant and numerators
   always_comb begin
      det_in = RW'(prd_ff[0]) - RW'(prd_ff[1]);
      nu_in  = RW'(prd_ff[2]) - RW'(prd_ff[3]);
      nv_in  = RW'(prd_ff[4]) - RW'(prd_ff[5]);
   end

   // stage 7: exact comparisons
   always_comb begin
      logic signed [CMPW-1:0] det_c, thr_c;
      logic signed [SW-1:0]   nsum;
      det_c = CMPW'(det_ff);
      thr_c = $signed({{(CMPW-THRESH_WIDTH){1'b0}}, threshold_ff});
      nsum  = SW'(nu_ff) + SW'(nv_ff);
      degen_in  = det_c <= thr_c;
      inside_in = !degen_in
               && !nu_ff[RW-1] && (nu_ff <= det_ff)
               && !nv_ff[RW-1] && (nv_ff <= det_ff)
               && (nsum <= SW'(det_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         threshold_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         threshold_ff <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         edge_ff <= edge_in;
      end
      if (stage_en[1]) begin
         eprod_ff <= eprod_in;
      end
      if (stage_en[2]) begin
         dot_ff <= dot_in;
      end
      if (stage_en[3]) begin
         part_ff <= part_in;
      end
      if (stage_en[4]) begin
         prd_ff <= prd_in;
      end
      if (stage_en[5]) begin
         det_ff <= det_in;
         nu_ff  <= nu_in;
         nv_ff  <= nv_in;
      end
      if (stage_en[6]) begin
         inside_ff <= inside_in;
         degen_ff  <= degen_in;
      end
   end

   // input is refused only when every stage holds an item
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input stalled with a free pipeline stage");

   // a degenerate triangle never reports the point inside
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_res |-> !rsp_degenerate)
      else $error("inside reported for degenerate triangle");

   // a result held on the output keeps the stage behind it from draining into it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(degen_ff))
      else $error("held result lost or changed");

endmodule
